// ----- rtl/mlt_pkg.sv -----
// Shared types and constants of the tremolo block: configuration bundle,
// register index codes, fixed-point constants and the sine entry builder.
// Used by mlt_cfg, mlt_sine_rom and mixed_lfo_tremolo.
`default_nettype none

package mlt_pkg;

	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SINE_LEVEL   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAW_LEVEL    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_LEVEL = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MIX_PERCENT  = 3'd4;

	localparam logic [6:0]  MIX_FULL  = 7'd100;
	localparam logic [22:0] HALF_DEN  = 23'd3276800;
	localparam logic [4:0]  DIV_REST  = 5'd25;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [30:0] ROUND_Q14 = 31'd8192;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [31:0] phase_step;
		logic [15:0] sine_level;
		logic [15:0] saw_level;
		logic [15:0] square_level;
		logic [6:0]  mix;
	} cfg_t;

	// 32768 + 32768*sin(2*pi*frac/2^32), built by quadrant folding and a Q30 series
	function automatic logic [16:0] sine_entry(input logic [63:0] frac);
		logic [1:0]  quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] mag;
		quad = frac[31:30];
		r = {34'd0, frac[29:0]};
		if (quad[0]) begin
			r = {33'd0, ONE_Q30} - r;
		end
		x = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum = sum - term;
		mag = (sum + 64'd16384) >> 15;
		if (mag > 64'd32768) begin
			mag = 64'd32768;
		end
		return quad[1] ? 17'(64'd32768 - mag) : 17'(64'd32768 + mag);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mlt_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// Operands are selected by the sequencer in mixed_lfo_tremolo.
`default_nettype none

module mlt_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

`default_nettype wire

// ----- rtl/mlt_sine_rom.sv -----
// Sine table ROM with registered read data.
// Entries come from mlt_pkg::sine_entry, evaluated at elaboration.
`default_nettype none

module mlt_sine_rom #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH)
) (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] addr,
	output logic      [16:0]      data_q
);

	logic [16:0] rom [SINE_TABLE_DEPTH];

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [63:0] FRAC = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
		assign rom[i] = mlt_pkg::sine_entry(FRAC);
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

endmodule

`default_nettype wire

// ----- rtl/mlt_cfg.sv -----
// Configuration register file of the tremolo block.
// Decodes the index, clamps the mix percent; depends on mlt_pkg.
`default_nettype none

module mlt_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [mlt_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  wire logic [31:0]                        wr_data,
	output mlt_pkg::cfg_t                           cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				mlt_pkg::REG_PHASE_STEP:   cfg_q.phase_step <= wr_data;
				mlt_pkg::REG_SINE_LEVEL:   cfg_q.sine_level <= wr_data[15:0];
				mlt_pkg::REG_SAW_LEVEL:    cfg_q.saw_level <= wr_data[15:0];
				mlt_pkg::REG_SQUARE_LEVEL: cfg_q.square_level <= wr_data[15:0];
				mlt_pkg::REG_MIX_PERCENT: begin
					cfg_q.mix <= (wr_data[6:0] > mlt_pkg::MIX_FULL) ? mlt_pkg::MIX_FULL
						: wr_data[6:0];
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mixed_lfo_tremolo.sv -----
// Tremolo top level: sequencer and datapath around one shared multiplier.
// Each accepted sample steps through S_IDX to S_OUT before output valid is set;
// only one sample is in flight at a time, set by the multiplier sequence.
// Input is stalled while an item is in flight or its result cannot be stored.
// Reset clears configuration, both phases and the output valid flag.
`default_nettype none

module mixed_lfo_tremolo #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned SAMPLE_WIDTH = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]           out_sample,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mlt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [31:0]                         cfg_data
);

	localparam int unsigned SW = SAMPLE_WIDTH;
	localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam logic [63:0] RECIP_FULL = (64'd1 << (SAMPLE_WIDTH + 4)) / 64'(mlt_pkg::DIV_REST);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_IDX  = 4'd1;
	localparam logic [3:0] S_SAW  = 4'd2;
	localparam logic [3:0] S_SIN  = 4'd3;
	localparam logic [3:0] S_MOD  = 4'd4;
	localparam logic [3:0] S_MIX  = 4'd5;
	localparam logic [3:0] S_FMIX = 4'd6;
	localparam logic [3:0] S_PROD = 4'd7;
	localparam logic [3:0] S_ZQ   = 4'd8;
	localparam logic [3:0] S_EST  = 4'd9;
	localparam logic [3:0] S_QE   = 4'd10;
	localparam logic [3:0] S_FIX  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	mlt_pkg::cfg_t cfg;

	logic [3:0]      state_q;
	logic [31:0]     cycle_phase_q;
	logic [31:0]     saw_phase_q;
	logic [SW-1:0]   mag_q;
	logic            neg_q;
	logic [32:0]     acc_q;
	logic [16:0]     mod_q;
	logic [22:0]     f_q;
	logic [SW+3:0]   z_q;
	logic [SW-1:0]   qe_q;
	logic [SW-1:0]   q_q;
	logic            out_valid_q;
	logic [SW-1:0]   out_sample_q;

	logic [31:0]     mul_a;
	logic [31:0]     mul_b;
	logic [63:0]     p_q;
	logic [16:0]     rom_data;
	logic            in_acc;
	logic            out_free;
	logic [SW-1:0]   mag_d;
	logic [33:0]     mod_sum;
	logic [30:0]     mod_clip;
	logic [30:0]     mod_round;
	logic [SW+22:0]  z_round;
	logic [SW+3:0]   rem;
	logic [1:0]      corr;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_sample = $signed(out_sample_q);

	mlt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg_q    (cfg)
	);

	mlt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	mlt_sine_rom #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.IDX_W            (IDX_W)
	) u_rom (
		.clk    (clk),
		.addr   (p_q[32 +: IDX_W]),
		.data_q (rom_data)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_IDX: begin
				mul_a = cycle_phase_q;
				mul_b = 32'(SINE_TABLE_DEPTH);
			end
			S_SAW: begin
				mul_a = 32'({~saw_phase_q[31], saw_phase_q[30:16]});
				mul_b = 32'(cfg.saw_level);
			end
			S_SIN: begin
				mul_a = 32'(rom_data);
				mul_b = 32'(cfg.sine_level);
			end
			S_MIX: begin
				mul_a = 32'(mod_q);
				mul_b = 32'(cfg.mix);
			end
			S_PROD: begin
				mul_a = 32'(mag_q);
				mul_b = 32'(f_q);
			end
			S_EST: begin
				mul_a = 32'(z_q[SW+3:4]);
				mul_b = 32'(RECIP_FULL[SW-1:0]);
			end
			S_QE: begin
				mul_a = 32'(p_q[SW +: SW]);
				mul_b = 32'(mlt_pkg::DIV_REST);
			end
			default: ;
		endcase
	end

	always_comb begin
		mag_d = in_sample[SW-1] ? (~in_sample + 1'b1) : in_sample;
		mod_sum = 34'(acc_q) + 34'(p_q[31:0]);
		mod_clip = (mod_sum > 34'(mlt_pkg::ONE_Q30)) ? mlt_pkg::ONE_Q30 : mod_sum[30:0];
		mod_round = mod_clip + mlt_pkg::ROUND_Q14;
		z_round = p_q[SW+22:0] + (SW+23)'(mlt_pkg::HALF_DEN);
		rem = z_q - p_q[SW+3:0];
		priority if (rem >= (SW+4)'(2 * mlt_pkg::DIV_REST)) begin
			corr = 2'd2;
		end else if (rem >= (SW+4)'(mlt_pkg::DIV_REST)) begin
			corr = 2'd1;
		end else begin
			corr = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= mag_d;
			neg_q <= in_sample[SW-1];
		end
		if (state_q == S_SIN) begin
			acc_q <= 33'(p_q[31:0])
				+ (cycle_phase_q[31] ? {1'b0, cfg.square_level, 16'd0} : 33'd0);
		end
		if (state_q == S_MOD) begin
			mod_q <= mod_round[30:14];
		end
		if (state_q == S_FMIX) begin
			f_q <= {mlt_pkg::MIX_FULL - cfg.mix, 16'd0} + p_q[22:0];
		end
		if (state_q == S_ZQ) begin
			z_q <= z_round[SW+21:18];
		end
		if (state_q == S_QE) begin
			qe_q <= p_q[SW +: SW];
		end
		if (state_q == S_FIX) begin
			q_q <= qe_q + SW'(corr);
		end
		if (state_q == S_OUT && out_free) begin
			out_sample_q <= neg_q ? (~q_q + 1'b1) : q_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cycle_phase_q <= '0;
			saw_phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_IDX;
					end
				end
				S_IDX:  state_q <= S_SAW;
				S_SAW:  state_q <= S_SIN;
				S_SIN:  state_q <= S_MOD;
				S_MOD:  state_q <= S_MIX;
				S_MIX:  state_q <= S_FMIX;
				S_FMIX: state_q <= S_PROD;
				S_PROD: state_q <= S_ZQ;
				S_ZQ:   state_q <= S_EST;
				S_EST:  state_q <= S_QE;
				S_QE:   state_q <= S_FIX;
				S_FIX:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						cycle_phase_q <= cycle_phase_q + cfg.phase_step;
						saw_phase_q <= saw_phase_q + {1'b0, cfg.phase_step[31:1]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("output valid rose outside the output step");

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=>
			cycle_phase_q == $past(cycle_phase_q) + $past(cfg.phase_step))
		else $error("phase did not advance by one step");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MIX |-> mod_q <= 17'd65536)
		else $error("modulation depth out of range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIX |-> rem < (SW+4)'(3 * mlt_pkg::DIV_REST))
		else $error("reciprocal estimate off by more than two");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> q_q <= mag_q)
		else $error("output magnitude exceeds input magnitude");

endmodule

`default_nettype wire
